// ===== sv/hkts_pkg.sv =====
// ----------------------------------------------------------------------------
// hkts_pkg
// Shared types and constants of the key-tap sequencer: field widths, event
// and status codes, and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package hkts_pkg;

    localparam int MODE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int TICK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int QUEUED_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Event codes carried by the mode field.
    localparam logic [MODE_W-1:0] MODE_REQUEST   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINK_UP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LINK_DOWN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OUTCOME   = 3'd4;

    // Request results.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOLINK  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRY   = 2'd2;

    localparam logic [TICK_W-1:0] HOLD_TICKS_RST  = 16'd120;
    localparam logic [TICK_W-1:0] RETRY_TICKS_RST = 16'd800;
    localparam logic [BYTE_W-1:0] MAX_RETRY_RST   = 8'd20;

    typedef struct packed {
        logic capture;  // latch the accepted transaction
        logic exec;     // apply the latched transaction and load the result
    } t_dp_cmd;

endpackage

// ===== sv/hkts_ctrl.sv =====
// ----------------------------------------------------------------------------
// hkts_ctrl
// Handshake controller: accepts one transaction, steps the datapath through
// it and holds the result valid until the consumer takes it.
// ----------------------------------------------------------------------------
module hkts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hkts_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    // A new transaction may enter once the result register is empty or is
    // being emptied in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_out_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/hkts_datapath.sv =====
// ----------------------------------------------------------------------------
// hkts_datapath
// Tap state, configuration registers, request queue memory and the result
// register. Tap state, queue and result update only on the execute command.
// ----------------------------------------------------------------------------
module hkts_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hkts_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_cfg_wr_en,
    input  logic [hkts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hkts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [hkts_pkg::MODE_W-1:0]       i_mode,
    input  logic [hkts_pkg::BYTE_W-1:0]       i_modifier,
    input  logic [hkts_pkg::BYTE_W-1:0]       i_keycode,
    input  logic                              i_send_ok,
    output logic                              o_report_valid,
    output logic [hkts_pkg::BYTE_W-1:0]       o_report_modifier,
    output logic [hkts_pkg::BYTE_W-1:0]       o_report_keycode,
    output logic [hkts_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_busy_res,
    output logic [hkts_pkg::QUEUED_W-1:0]     o_queued,
    output logic                              o_linked
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 2 * hkts_pkg::BYTE_W;
    localparam int BW = hkts_pkg::BYTE_W;
    localparam int TW = hkts_pkg::TICK_W;

    typedef enum logic [1:0] {
        PH_PRESS_DUE,
        PH_PRESS_SENT,
        PH_RELEASE_DUE,
        PH_RELEASE_SENT
    } t_phase;

    // Configuration.
    logic [TW-1:0] r_hold_ticks;
    logic [TW-1:0] r_retry_ticks;
    logic [BW-1:0] r_max_retry;

    // Latched transaction.
    logic [hkts_pkg::MODE_W-1:0] r_mode;
    logic [BW-1:0]               r_modifier;
    logic [BW-1:0]               r_keycode;
    logic                        r_send_ok;

    // Tap state.
    logic          r_link,    n_link;
    logic          r_active,  n_active;
    t_phase        r_phase,   n_phase;
    logic [TW-1:0] r_timer,   n_timer;
    logic [BW-1:0] r_retry,   n_retry;
    logic [BW-1:0] r_cur_mod, n_cur_mod;
    logic [BW-1:0] r_cur_key, n_cur_key;
    logic [AW-1:0] r_head,    n_head;
    logic [AW-1:0] r_tail,    n_tail;
    logic [CW-1:0] r_count,   n_count;

    // Queue memory; the head entry is read every cycle into r_rd_data.
    logic [EW-1:0] r_fifo_mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd_data;

    logic                          push;
    logic                          rep_valid;
    logic [BW-1:0]                 rep_mod;
    logic [BW-1:0]                 rep_key;
    logic [hkts_pkg::STATUS_W-1:0] status;
    logic                          fail;
    t_phase                        fail_phase;
    logic                          end_req;
    logic [BW-1:0]                 retry_inc;
    logic [CW+hkts_pkg::QUEUED_W-1:0] count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks  <= hkts_pkg::HOLD_TICKS_RST;
            r_retry_ticks <= hkts_pkg::RETRY_TICKS_RST;
            r_max_retry   <= hkts_pkg::MAX_RETRY_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hkts_pkg::CFG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                hkts_pkg::CFG_RETRY_TICKS: r_retry_ticks <= i_cfg_data;
                hkts_pkg::CFG_MAX_RETRY:   r_max_retry   <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_modifier <= i_modifier;
            r_keycode  <= i_keycode;
            r_send_ok  <= i_send_ok;
        end
    end

    always_comb begin
        n_link     = r_link;
        n_active   = r_active;
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_retry    = r_retry;
        n_cur_mod  = r_cur_mod;
        n_cur_key  = r_cur_key;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        push       = 1'b0;
        rep_valid  = 1'b0;
        rep_mod    = '0;
        rep_key    = '0;
        status     = hkts_pkg::ST_OK;
        fail       = 1'b0;
        fail_phase = PH_PRESS_DUE;
        end_req    = 1'b0;
        retry_inc  = r_retry + 1'b1;

        case (r_mode)
            hkts_pkg::MODE_REQUEST: begin
                if (r_keycode == '0) begin
                    status = hkts_pkg::ST_INVALID;
                end else if (!r_link) begin
                    status = hkts_pkg::ST_NOLINK;
                end else if (r_active) begin
                    if (r_count == CW'(QUEUE_DEPTH)) begin
                        status = hkts_pkg::ST_FULL;
                    end else begin
                        push    = 1'b1;
                        n_tail  = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_active  = 1'b1;
                    n_retry   = '0;
                    n_cur_mod = r_modifier;
                    n_cur_key = r_keycode;
                    n_timer   = '0;
                    n_phase   = PH_PRESS_SENT;
                    rep_valid = 1'b1;
                    rep_mod   = r_modifier;
                    rep_key   = r_keycode;
                end
            end
            hkts_pkg::MODE_TICK: begin
                if (r_active && (r_phase == PH_PRESS_DUE || r_phase == PH_RELEASE_DUE)) begin
                    if (r_timer <= TW'(1)) begin
                        n_timer   = '0;
                        rep_valid = 1'b1;
                        if (r_phase == PH_PRESS_DUE) begin
                            n_phase = PH_PRESS_SENT;
                            rep_mod = r_cur_mod;
                            rep_key = r_cur_key;
                        end else begin
                            n_phase = PH_RELEASE_SENT;
                        end
                    end else begin
                        n_timer = r_timer - 1'b1;
                    end
                end
            end
            hkts_pkg::MODE_LINK_UP, hkts_pkg::MODE_LINK_DOWN: begin
                n_link    = (r_mode == hkts_pkg::MODE_LINK_UP);
                n_active  = 1'b0;
                n_phase   = PH_PRESS_DUE;
                n_timer   = '0;
                n_retry   = '0;
                n_cur_mod = '0;
                n_cur_key = '0;
                n_head    = '0;
                n_tail    = '0;
                n_count   = '0;
            end
            hkts_pkg::MODE_OUTCOME: begin
                if (r_active && r_phase == PH_PRESS_SENT) begin
                    if (r_send_ok) begin
                        n_retry = '0;
                        n_timer = r_hold_ticks;
                        n_phase = PH_RELEASE_DUE;
                    end else begin
                        fail       = 1'b1;
                        fail_phase = PH_PRESS_DUE;
                    end
                end else if (r_active && r_phase == PH_RELEASE_SENT) begin
                    if (r_send_ok) begin
                        end_req = 1'b1;
                    end else begin
                        fail       = 1'b1;
                        fail_phase = PH_RELEASE_DUE;
                    end
                end
            end
            default: ;
        endcase

        // The failure count is checked after it is bumped.
        if (fail) begin
            n_retry = retry_inc;
            if (retry_inc < r_max_retry) begin
                n_timer = r_retry_ticks;
                n_phase = fail_phase;
            end else begin
                end_req = 1'b1;
            end
        end

        // A finished or dropped tap hands over to the oldest queued one at once.
        if (end_req) begin
            n_active  = 1'b0;
            n_retry   = '0;
            n_cur_mod = '0;
            n_cur_key = '0;
            n_timer   = '0;
            n_phase   = PH_PRESS_DUE;
            if (!r_link) begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end else if (r_count != '0) begin
                n_head    = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_count   = r_count - 1'b1;
                n_active  = 1'b1;
                n_cur_mod = r_rd_data[EW-1:BW];
                n_cur_key = r_rd_data[BW-1:0];
                n_phase   = PH_PRESS_SENT;
                rep_valid = 1'b1;
                rep_mod   = r_rd_data[EW-1:BW];
                rep_key   = r_rd_data[BW-1:0];
            end
        end

        count_ext = {{hkts_pkg::QUEUED_W{1'b0}}, n_count};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link    <= 1'b0;
            r_active  <= 1'b0;
            r_phase   <= PH_PRESS_DUE;
            r_timer   <= '0;
            r_retry   <= '0;
            r_cur_mod <= '0;
            r_cur_key <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else if (i_cmd.exec) begin
            r_link    <= n_link;
            r_active  <= n_active;
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_retry   <= n_retry;
            r_cur_mod <= n_cur_mod;
            r_cur_key <= n_cur_key;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
        end
    end

    // The head address never moves in the cycle before an execute, so the
    // registered read is always current when a queued tap is started.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push) begin
            r_fifo_mem[r_tail] <= {r_modifier, r_keycode};
        end
        r_rd_data <= r_fifo_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_report_valid    <= rep_valid;
            o_report_modifier <= rep_mod;
            o_report_keycode  <= rep_key;
            o_status          <= status;
            o_busy_res        <= n_active;
            o_queued          <= count_ext[hkts_pkg::QUEUED_W-1:0];
            o_linked          <= n_link;
        end
    end

endmodule

// ===== sv/hid_key_tap_sequencer.sv =====
// ----------------------------------------------------------------------------
// hid_key_tap_sequencer
// Keyboard key-tap sequencer: press and release reports, hold timing, send
// retries and a queue of pending tap requests.
// ----------------------------------------------------------------------------
// Each transaction is latched when it is accepted; the datapath then applies
// it and loads the result register. The next event is accepted once the
// controller is idle and the result register is empty or is being taken in
// the same cycle, so no new event enters while the last one is being
// applied. Pending requests are held in a QUEUE_DEPTH-entry memory with a
// registered read of the head entry; it needs no clearing pass after reset.
// Configuration writes (hold ticks, retry ticks, retry limit) take effect at
// once and are meant to be made while no transaction is in flight.
module hid_key_tap_sequencer #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [hkts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hkts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [hkts_pkg::MODE_W-1:0]       i_mode,
    input  logic [hkts_pkg::BYTE_W-1:0]       i_modifier,
    input  logic [hkts_pkg::BYTE_W-1:0]       i_keycode,
    input  logic                              i_send_ok,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_report_valid,
    output logic [hkts_pkg::BYTE_W-1:0]       o_report_modifier,
    output logic [hkts_pkg::BYTE_W-1:0]       o_report_keycode,
    output logic [hkts_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_busy_res,
    output logic [hkts_pkg::QUEUED_W-1:0]     o_queued,
    output logic                              o_linked
);

    hkts_pkg::t_dp_cmd cmd;

    hkts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    hkts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_modifier        (i_modifier),
        .i_keycode         (i_keycode),
        .i_send_ok         (i_send_ok),
        .o_report_valid    (o_report_valid),
        .o_report_modifier (o_report_modifier),
        .o_report_keycode  (o_report_keycode),
        .o_status          (o_status),
        .o_busy_res        (o_busy_res),
        .o_queued          (o_queued),
        .o_linked          (o_linked)
    );

endmodule
